### src/hill_rk4_pkg.sv
package hill_rk4_pkg;

  localparam int unsigned FRAC_BITS_DEF = 16;
  localparam int unsigned SER_STEPS     = 32;

  localparam logic [16:0] DT_RST           = 17'd655;
  localparam logic [20:0] ANGULAR_RATE_RST = 21'd65536;

  // configuration register indexes
  localparam logic CFG_DT           = 1'b0;
  localparam logic CFG_ANGULAR_RATE = 1'b1;

  // operand / destination codes: below 32 is scratch memory, 32 and above is special
  localparam logic [5:0] A_ST = 6'd0;   // stage state, six words
  localparam logic [5:0] A_K  = 6'd6;   // current derivative, six words
  localparam logic [5:0] A_SM = 6'd12;  // weighted derivative sum, six words
  localparam logic [5:0] A_C0 = 6'd18;
  localparam logic [5:0] A_C1 = 6'd19;
  localparam logic [5:0] A_C2 = 6'd20;
  localparam logic [5:0] A_C3 = 6'd21;
  localparam logic [5:0] A_T0 = 6'd22;
  localparam logic [5:0] A_T1 = 6'd23;
  localparam logic [5:0] A_DT = 6'd32;
  localparam logic [5:0] A_W  = 6'd33;
  localparam logic [5:0] A_S0 = 6'd34;  // stored state, six words
  localparam logic [5:0] A_U  = 6'd40;  // thrust, three words

  typedef enum logic [2:0] {
    OP_MOV,
    OP_ADD,
    OP_NEG,
    OP_HALF,
    OP_MUL,
    OP_DIV6
  } op_e;

  typedef enum logic [1:0] {
    SEG_COEF,
    SEG_DERIV,
    SEG_ACC,
    SEG_UPD
  } seg_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_EXEC,
    S_SERIAL,
    S_FIN
  } state_e;

  typedef struct packed {
    op_e        op;
    logic [5:0] dst;
    logic [5:0] sa;
    logic [5:0] sb;
    logic       last;
  } uop_t;

  function automatic uop_t mk(input op_e op, input logic [5:0] dst, input logic [5:0] sa,
                              input logic [5:0] sb, input logic last);
    uop_t u;
    u.op   = op;
    u.dst  = dst;
    u.sa   = sa;
    u.sb   = sb;
    u.last = last;
    return u;
  endfunction

  // Microprogram: stage 0..3 of the step, segment, sub-step and lane.
  function automatic uop_t get_uop(input logic [1:0] stage, input seg_e seg,
                                   input logic [3:0] idx, input logic [2:0] lane);
    uop_t       u;
    logic [5:0] b;
    logic [5:0] l;
    b = (stage == 2'd0) ? A_S0 : A_ST;
    l = 6'(lane);
    u = mk(OP_MOV, A_T0, A_T0, A_T0, 1'b1);
    case (seg)
      SEG_COEF: begin
        case (idx)
          4'd0:    u = mk(OP_ADD, A_C0, A_W, A_W, 1'b0);
          4'd1:    u = mk(OP_NEG, A_C1, A_C0, A_C0, 1'b0);
          4'd2:    u = mk(OP_ADD, A_T0, A_C0, A_W, 1'b0);
          4'd3:    u = mk(OP_MUL, A_C2, A_T0, A_W, 1'b0);
          4'd4:    u = mk(OP_MUL, A_T0, A_W, A_W, 1'b0);
          default: u = mk(OP_NEG, A_C3, A_T0, A_T0, 1'b1);
        endcase
      end
      SEG_DERIV: begin
        case (idx)
          4'd0:    u = mk(OP_MOV, A_K,        b + 6'd3, A_T0, 1'b0);
          4'd1:    u = mk(OP_MOV, A_K + 6'd1, b + 6'd4, A_T0, 1'b0);
          4'd2:    u = mk(OP_MOV, A_K + 6'd2, b + 6'd5, A_T0, 1'b0);
          4'd3:    u = mk(OP_MUL, A_T0,       b + 6'd4, A_C0, 1'b0);
          4'd4:    u = mk(OP_ADD, A_K + 6'd3, A_T0, A_U, 1'b0);
          4'd5:    u = mk(OP_MUL, A_T0,       b + 6'd3, A_C1, 1'b0);
          4'd6:    u = mk(OP_MUL, A_T1,       b + 6'd1, A_C2, 1'b0);
          4'd7:    u = mk(OP_ADD, A_T0,       A_T0, A_T1, 1'b0);
          4'd8:    u = mk(OP_ADD, A_K + 6'd4, A_T0, A_U + 6'd1, 1'b0);
          4'd9:    u = mk(OP_MUL, A_T0,       b + 6'd2, A_C3, 1'b0);
          default: u = mk(OP_ADD, A_K + 6'd5, A_T0, A_U + 6'd2, 1'b1);
        endcase
      end
      SEG_ACC: begin
        if (stage == 2'd0) begin
          u = mk(OP_MOV, A_SM + l, A_K + l, A_T0, 1'b1);
        end else if (stage == 2'd3) begin
          u = mk(OP_ADD, A_SM + l, A_SM + l, A_K + l, 1'b1);
        end else if (idx == 4'd0) begin
          u = mk(OP_ADD, A_T0, A_K + l, A_K + l, 1'b0);
        end else begin
          u = mk(OP_ADD, A_SM + l, A_SM + l, A_T0, 1'b1);
        end
      end
      default: begin
        if (stage == 2'd3) begin
          case (idx)
            4'd0:    u = mk(OP_MUL, A_T0, A_DT, A_SM + l, 1'b0);
            4'd1:    u = mk(OP_DIV6, A_T0, A_T0, A_T0, 1'b0);
            default: u = mk(OP_ADD, A_S0 + l, A_S0 + l, A_T0, 1'b1);
          endcase
        end else if (stage == 2'd2) begin
          case (idx)
            4'd0:    u = mk(OP_MUL, A_T0, A_DT, A_K + l, 1'b0);
            default: u = mk(OP_ADD, A_ST + l, A_S0 + l, A_T0, 1'b1);
          endcase
        end else begin
          case (idx)
            4'd0:    u = mk(OP_MUL, A_T0, A_DT, A_K + l, 1'b0);
            4'd1:    u = mk(OP_HALF, A_T0, A_T0, A_T0, 1'b0);
            default: u = mk(OP_ADD, A_ST + l, A_S0 + l, A_T0, 1'b1);
          endcase
        end
      end
    endcase
    return u;
  endfunction

endpackage

### src/hill_equations_rk4_step.sv
// Relative-orbit integrator: one RK4 step of the Hill equations per step input transfer.
// Input channel s_axis: tuser carries kind (0 = step with thrust, 1 = load state),
// tdata carries thrust and load values. Output channel m_axis: one result transfer
// per input transfer with the new state and integer grid coordinates.
// Configuration: cfg_we_i writes the time step dt (index 0) or angular_rate (index 1);
// write only while the block is idle.
// A load item goes straight from idle to the final state. A step item runs a
// microprogram of 152 operations on a scratch memory: 104 simple ones and 48
// multiplies and divides by 6, which go through one shared bit-serial unit. One
// item is worked on at a time; the serial unit sets the rate.
// The next item is accepted while a result still waits in the output register;
// when the receiver stalls, the block holds its finished result in a final state
// and accepts nothing more until that transfer completes.
// Reset sets position and velocity to zero, dt to 655 and angular_rate
// to 65536, and empties the output register.
module hill_equations_rk4_step #(
  parameter int unsigned FRAC_BITS = hill_rk4_pkg::FRAC_BITS_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // thrust_x, thrust_y, thrust_z, load_px, load_py, load_pz, load_vx, load_vy, load_vz
  input  logic [287:0] s_axis_tdata,
  // kind
  input  logic         s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, grid_col, grid_row
  output logic [223:0] m_axis_tdata,
  input  logic         cfg_we_i,
  input  logic         cfg_idx_i,
  input  logic [20:0]  cfg_data_i
);

  localparam logic [32:0] GRID_BIAS = (33'd1 << FRAC_BITS) - 33'd1;

  hill_rk4_pkg::state_e state_q, state_d;

  logic [16:0] step_q;
  logic [20:0] rate_q;

  logic signed [31:0] sv_q [6];  // px, py, pz, vx, vy, vz
  logic signed [31:0] u_q  [3];

  logic [31:0] mem [32];
  logic signed [31:0] rd_a_q, rd_b_q;

  logic [1:0]         stage_q;
  hill_rk4_pkg::seg_e seg_q;
  logic [3:0]         idx_q;
  logic [2:0]         lane_q;
  hill_rk4_pkg::uop_t uop;

  logic [63:0] prod_q;
  logic [31:0] mcand_q;
  logic [2:0]  rem_q;
  logic        neg_q;
  logic [5:0]  cnt_q;

  logic         out_valid_q;
  logic [223:0] out_data_q;

  logic signed [31:0] opa, opb, res, mul_res, div_res;
  logic signed [32:0] sum33;
  logic [64:0] mag65, sp65, sh65;
  logic        is_serial, wr_en, seq_done, in_xfer;
  logic [32:0] ser_add;
  logic [3:0]  div_t;
  logic        div_ge;

  assign uop     = hill_rk4_pkg::get_uop(stage_q, seg_q, idx_q, lane_q);
  assign in_xfer = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == hill_rk4_pkg::S_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  assign is_serial = (uop.op == hill_rk4_pkg::OP_MUL) || (uop.op == hill_rk4_pkg::OP_DIV6);
  assign wr_en = ((state_q == hill_rk4_pkg::S_EXEC) && !is_serial) ||
                 ((state_q == hill_rk4_pkg::S_SERIAL) &&
                  (cnt_q == 6'(hill_rk4_pkg::SER_STEPS)));
  assign seq_done = (seg_q == hill_rk4_pkg::SEG_UPD) && (stage_q == 2'd3) &&
                    uop.last && (lane_q == 3'd5);

  // operand select
  always_comb begin
    if (!uop.sa[5]) begin
      opa = rd_a_q;
    end else if (uop.sa == hill_rk4_pkg::A_DT) begin
      opa = {15'd0, step_q};
    end else if (uop.sa == hill_rk4_pkg::A_W) begin
      opa = {11'd0, rate_q};
    end else begin
      opa = sv_q[3'(uop.sa - hill_rk4_pkg::A_S0)];
    end
    if (!uop.sb[5]) begin
      opb = rd_b_q;
    end else if (uop.sb == hill_rk4_pkg::A_W) begin
      opb = {11'd0, rate_q};
    end else begin
      opb = u_q[2'(uop.sb - hill_rk4_pkg::A_U)];
    end
  end

  // result of the current operation
  always_comb begin
    sum33 = {opa[31], opa} + {opb[31], opb};
    mag65 = {1'b0, prod_q};
    sp65  = neg_q ? (~mag65 + 65'd1) : mag65;
    sh65  = 65'($signed(sp65) >>> FRAC_BITS);
    if (!sh65[64] && (|sh65[63:31])) begin
      mul_res = 32'sh7fffffff;
    end else if (sh65[64] && !(&sh65[63:31])) begin
      mul_res = 32'sh80000000;
    end else begin
      mul_res = sh65[31:0];
    end
    div_res = neg_q ? -$signed(prod_q[31:0]) : $signed(prod_q[31:0]);
    case (uop.op)
      hill_rk4_pkg::OP_ADD: begin
        if (sum33[32] != sum33[31]) begin
          res = sum33[32] ? 32'sh80000000 : 32'sh7fffffff;
        end else begin
          res = sum33[31:0];
        end
      end
      hill_rk4_pkg::OP_NEG:  res = (opa == 32'sh80000000) ? 32'sh7fffffff : -opa;
      hill_rk4_pkg::OP_HALF: res = opa >>> 1;
      hill_rk4_pkg::OP_MUL:  res = mul_res;
      hill_rk4_pkg::OP_DIV6: res = div_res;
      default:               res = opa;
    endcase
  end

  // serial unit step
  always_comb begin
    ser_add = {1'b0, prod_q[63:32]} + (prod_q[0] ? {1'b0, mcand_q} : 33'd0);
    div_t   = {rem_q, prod_q[31]};
    div_ge  = (div_t >= 4'd6);
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      hill_rk4_pkg::S_IDLE: begin
        if (in_xfer) begin
          state_d = s_axis_tuser ? hill_rk4_pkg::S_FIN : hill_rk4_pkg::S_READ;
        end
      end
      hill_rk4_pkg::S_READ: state_d = hill_rk4_pkg::S_EXEC;
      hill_rk4_pkg::S_EXEC: begin
        if (is_serial) begin
          state_d = hill_rk4_pkg::S_SERIAL;
        end else begin
          state_d = seq_done ? hill_rk4_pkg::S_FIN : hill_rk4_pkg::S_READ;
        end
      end
      hill_rk4_pkg::S_SERIAL: begin
        if (wr_en) begin
          state_d = seq_done ? hill_rk4_pkg::S_FIN : hill_rk4_pkg::S_READ;
        end
      end
      hill_rk4_pkg::S_FIN: begin
        if (!out_valid_q || m_axis_tready) begin
          state_d = hill_rk4_pkg::S_IDLE;
        end
      end
      default: state_d = hill_rk4_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= hill_rk4_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= hill_rk4_pkg::DT_RST;
      rate_q <= hill_rk4_pkg::ANGULAR_RATE_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        hill_rk4_pkg::CFG_DT:           step_q <= cfg_data_i[16:0];
        hill_rk4_pkg::CFG_ANGULAR_RATE: rate_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // scratch memory
  always_ff @(posedge clk_i) begin
    if (wr_en && !uop.dst[5]) begin
      mem[uop.dst[4:0]] <= res;
    end
    if (state_q == hill_rk4_pkg::S_READ) begin
      rd_a_q <= mem[uop.sa[4:0]];
      rd_b_q <= mem[uop.sb[4:0]];
    end
  end

  // stored state and latched thrust
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 6; i++) sv_q[i] <= '0;
    end else if (in_xfer && s_axis_tuser) begin
      for (int i = 0; i < 6; i++) sv_q[i] <= s_axis_tdata[96 + 32*i +: 32];
    end else if (wr_en && uop.dst[5]) begin
      sv_q[3'(uop.dst - hill_rk4_pkg::A_S0)] <= res;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      for (int i = 0; i < 3; i++) u_q[i] <= s_axis_tdata[32*i +: 32];
    end
  end

  // microprogram sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_q <= '0;
      seg_q   <= hill_rk4_pkg::SEG_COEF;
      idx_q   <= '0;
      lane_q  <= '0;
    end else if (in_xfer) begin
      stage_q <= '0;
      seg_q   <= hill_rk4_pkg::SEG_COEF;
      idx_q   <= '0;
      lane_q  <= '0;
    end else if (wr_en) begin
      if (!uop.last) begin
        idx_q <= idx_q + 4'd1;
      end else begin
        idx_q <= '0;
        if (((seg_q == hill_rk4_pkg::SEG_ACC) || (seg_q == hill_rk4_pkg::SEG_UPD)) &&
            (lane_q != 3'd5)) begin
          lane_q <= lane_q + 3'd1;
        end else begin
          lane_q <= '0;
          case (seg_q)
            hill_rk4_pkg::SEG_COEF:  seg_q <= hill_rk4_pkg::SEG_DERIV;
            hill_rk4_pkg::SEG_DERIV: seg_q <= hill_rk4_pkg::SEG_ACC;
            hill_rk4_pkg::SEG_ACC:   seg_q <= hill_rk4_pkg::SEG_UPD;
            default: begin
              seg_q   <= hill_rk4_pkg::SEG_DERIV;
              stage_q <= stage_q + 2'd1;
            end
          endcase
        end
      end
    end
  end

  // bit-serial multiplier and divide-by-six unit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if ((state_q == hill_rk4_pkg::S_EXEC) && is_serial) begin
      cnt_q <= '0;
    end else if ((state_q == hill_rk4_pkg::S_SERIAL) && !wr_en) begin
      cnt_q <= cnt_q + 6'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == hill_rk4_pkg::S_EXEC) && is_serial) begin
      rem_q <= '0;
      if (uop.op == hill_rk4_pkg::OP_MUL) begin
        mcand_q <= opa[31] ? 32'(-opa) : opa;
        prod_q  <= {32'd0, (opb[31] ? 32'(-opb) : opb)};
        neg_q   <= opa[31] ^ opb[31];
      end else begin
        prod_q  <= {32'd0, (opa[31] ? 32'(-opa) : opa)};
        neg_q   <= opa[31];
      end
    end else if ((state_q == hill_rk4_pkg::S_SERIAL) && !wr_en) begin
      if (uop.op == hill_rk4_pkg::OP_MUL) begin
        prod_q <= {ser_add, prod_q[31:1]};
      end else begin
        rem_q         <= div_ge ? 3'(div_t - 4'd6) : div_t[2:0];
        prod_q[31:0]  <= {prod_q[30:0], div_ge};
      end
    end
  end

  // grid coordinates: truncate toward zero, saturate to 16 bits
  function automatic logic [15:0] grid(input logic signed [31:0] p);
    logic [32:0] g;
    logic [32:0] s;
    g = {p[31], p} + (p[31] ? GRID_BIAS : 33'd0);
    s = 33'($signed(g) >>> FRAC_BITS);
    if (!s[32] && (|s[31:15])) begin
      return 16'h7fff;
    end else if (s[32] && !(&s[31:15])) begin
      return 16'h8000;
    end
    return s[15:0];
  endfunction

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if ((state_q == hill_rk4_pkg::S_FIN) && (!out_valid_q || m_axis_tready)) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == hill_rk4_pkg::S_FIN) && (!out_valid_q || m_axis_tready)) begin
      out_data_q <= {grid(sv_q[2]), grid(sv_q[0]), sv_q[5], sv_q[4], sv_q[3],
                     sv_q[2], sv_q[1], sv_q[0]};
    end
  end

  a_load_to_fin : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && s_axis_tuser) |=> (state_q == hill_rk4_pkg::S_FIN))
    else $error("load item did not go straight to result");

  a_serial_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == hill_rk4_pkg::S_SERIAL) |-> (cnt_q <= 6'(hill_rk4_pkg::SER_STEPS)))
    else $error("serial unit ran past its step count");

  a_out_from_fin : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> ($past(state_q) == hill_rk4_pkg::S_FIN))
    else $error("result appeared outside the final state");

endmodule
